// ===== hdl/chacha20_stream_cipher_top_macros.svh =====
// Assertion helpers for the cipher top level.
`ifndef CHACHA20_STREAM_CIPHER_TOP_MACROS_SVH
`define CHACHA20_STREAM_CIPHER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CC20_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define CC20_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/cc20_pkg.sv =====
package cc20_pkg;

  localparam int unsigned NUM_WORDS     = 16;
  localparam int unsigned IDX_W         = $clog2(NUM_WORDS);
  localparam int unsigned DOUBLE_ROUNDS = 10;
  localparam int unsigned ROUND_STEPS   = DOUBLE_ROUNDS * 32;
  localparam int unsigned RND_W         = $clog2(ROUND_STEPS);
  localparam int unsigned NUM_REGS      = 7;
  localparam int unsigned CFG_IDX_W     = $clog2(NUM_REGS);
  localparam int unsigned CFG_DATA_W    = 64;

  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646E;
  localparam logic [31:0] SIGMA2 = 32'h79622D32;
  localparam logic [31:0] SIGMA3 = 32'h6B206574;

  localparam int unsigned ROT_AD16 = 16;
  localparam int unsigned ROT_CB12 = 12;
  localparam int unsigned ROT_AD8  = 8;
  localparam int unsigned ROT_CB7  = 7;

  localparam logic [CFG_IDX_W-1:0] REG_KEY0     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY1     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY2     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY3     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE_LO = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE_HI = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_CTR = 3'd6;

  typedef logic [31:0] word_t;
  typedef logic [NUM_WORDS-1:0][31:0] state_t;
  typedef logic [3:0][63:0] key_t;

  typedef enum logic [1:0] {
    QS_AD16 = 2'd0,
    QS_CB12 = 2'd1,
    QS_AD8  = 2'd2,
    QS_CB7  = 2'd3
  } qstep_e;

  typedef enum logic [1:0] {
    ROT_NONE,
    ROT_QR,
    ROT_DIAG,
    ROT_UNDIAG
  } rot_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic in_valid;
    logic need_block;
    logic out_free;
  } sts_t;

  typedef struct packed {
    logic             ready;
    logic             load;
    logic             round_en;
    logic             add_en;
    logic             ctr_inc;
    logic             emit;
    qstep_e           step;
    rot_e             rot;
    logic [IDX_W-1:0] idx;
  } ctl_t;

  function automatic word_t rotl(word_t v, int unsigned s);
    return word_t'((v << s) | (v >> (32 - s)));
  endfunction

  function automatic state_t init_state(key_t key, logic [63:0] nonce_lo,
                                        logic [31:0] nonce_hi, word_t ctr);
    state_t s;
    s[0]  = SIGMA0;
    s[1]  = SIGMA1;
    s[2]  = SIGMA2;
    s[3]  = SIGMA3;
    for (int i = 0; i < 4; i++) begin
      s[4 + 2 * i] = key[i][31:0];
      s[5 + 2 * i] = key[i][63:32];
    end
    s[12] = ctr;
    s[13] = nonce_lo[31:0];
    s[14] = nonce_lo[63:32];
    s[15] = nonce_hi;
    return s;
  endfunction

  // Rotate each 4-word row left by its own amount.
  function automatic state_t rot_rows(state_t w, rot_e r);
    logic [3:0][1:0] k;
    logic [1:0]      jj;
    state_t          o;
    unique case (r)
      ROT_NONE:   k = {2'd0, 2'd0, 2'd0, 2'd0};
      ROT_QR:     k = {2'd1, 2'd1, 2'd1, 2'd1};
      ROT_DIAG:   k = {2'd0, 2'd3, 2'd2, 2'd1};
      ROT_UNDIAG: k = {2'd2, 2'd3, 2'd0, 2'd1};
      default:    k = {2'd0, 2'd0, 2'd0, 2'd0};
    endcase
    for (int row = 0; row < 4; row++) begin
      for (int j = 0; j < 4; j++) begin
        jj = 2'(j) + k[row];
        o[4 * row + j] = w[{2'(row), jj}];
      end
    end
    return o;
  endfunction

endpackage

// ===== hdl/cc20_qr.sv =====
module cc20_qr (
  input  cc20_pkg::qstep_e step_i,
  input  cc20_pkg::word_t  a_i,
  input  cc20_pkg::word_t  b_i,
  input  cc20_pkg::word_t  c_i,
  input  cc20_pkg::word_t  d_i,
  output cc20_pkg::word_t  a_o,
  output cc20_pkg::word_t  b_o,
  output cc20_pkg::word_t  c_o,
  output cc20_pkg::word_t  d_o
);

  cc20_pkg::word_t opl;
  cc20_pkg::word_t opr;
  cc20_pkg::word_t sum;

  always_comb begin
    opl = step_i[0] ? c_i : a_i;
    opr = step_i[0] ? d_i : b_i;
    sum = opl + opr;
    a_o = a_i;
    b_o = b_i;
    c_o = c_i;
    d_o = d_i;
    unique case (step_i)
      cc20_pkg::QS_AD16: begin
        a_o = sum;
        d_o = cc20_pkg::rotl(d_i ^ sum, cc20_pkg::ROT_AD16);
      end
      cc20_pkg::QS_CB12: begin
        c_o = sum;
        b_o = cc20_pkg::rotl(b_i ^ sum, cc20_pkg::ROT_CB12);
      end
      cc20_pkg::QS_AD8: begin
        a_o = sum;
        d_o = cc20_pkg::rotl(d_i ^ sum, cc20_pkg::ROT_AD8);
      end
      cc20_pkg::QS_CB7: begin
        c_o = sum;
        b_o = cc20_pkg::rotl(b_i ^ sum, cc20_pkg::ROT_CB7);
      end
      default: begin
        a_o = a_i;
      end
    endcase
  end

endmodule

// ===== hdl/cc20_ctrl.sv =====
module cc20_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cc20_pkg::sts_t sts_i,
  output cc20_pkg::ctl_t ctl_o
);

  cc20_pkg::state_e              state_q, state_d;
  logic [cc20_pkg::RND_W-1:0]    rnd_q, rnd_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cc20_pkg::ST_IDLE;
      rnd_q   <= '0;
    end else begin
      state_q <= state_d;
      rnd_q   <= rnd_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    rnd_d          = rnd_q;
    ctl_o          = '0;
    ctl_o.step     = cc20_pkg::QS_AD16;
    ctl_o.rot      = cc20_pkg::ROT_NONE;
    ctl_o.idx      = rnd_q[cc20_pkg::IDX_W-1:0];
    unique case (state_q)
      cc20_pkg::ST_IDLE: begin
        ctl_o.ready = 1'b1;
        rnd_d       = '0;
        if (sts_i.in_valid) begin
          ctl_o.load = sts_i.need_block;
          state_d    = sts_i.need_block ? cc20_pkg::ST_ROUND : cc20_pkg::ST_EMIT;
        end
      end
      cc20_pkg::ST_ROUND: begin
        ctl_o.round_en = 1'b1;
        ctl_o.step     = cc20_pkg::qstep_e'(rnd_q[1:0]);
        if (rnd_q[1:0] == 2'(cc20_pkg::QS_CB7)) begin
          if (rnd_q[3:2] != 2'd3) begin
            ctl_o.rot = cc20_pkg::ROT_QR;
          end else begin
            ctl_o.rot = rnd_q[4] ? cc20_pkg::ROT_UNDIAG : cc20_pkg::ROT_DIAG;
          end
        end
        if (rnd_q == cc20_pkg::RND_W'(cc20_pkg::ROUND_STEPS - 1)) begin
          rnd_d   = '0;
          state_d = cc20_pkg::ST_ADD;
        end else begin
          rnd_d = rnd_q + 1'b1;
        end
      end
      cc20_pkg::ST_ADD: begin
        ctl_o.add_en = 1'b1;
        if (rnd_q[cc20_pkg::IDX_W-1:0] == cc20_pkg::IDX_W'(cc20_pkg::NUM_WORDS - 1)) begin
          ctl_o.ctr_inc = 1'b1;
          rnd_d         = '0;
          state_d       = cc20_pkg::ST_EMIT;
        end else begin
          rnd_d = rnd_q + 1'b1;
        end
      end
      cc20_pkg::ST_EMIT: begin
        if (sts_i.out_free) begin
          ctl_o.emit = 1'b1;
          state_d    = cc20_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = cc20_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/chacha20_stream_cipher_top.sv =====
// ChaCha20 byte stream cipher (96-bit nonce, 32-bit block counter); encryption and
// decryption are the same. One byte per transaction in, one byte per transaction out,
// in order, with tlast passed through. A byte that is not at the start of a 64-byte
// block is accepted, then its result goes into the output register. For the first
// byte of each block a keystream block is made first: one quarter-round unit does
// one add/xor/rotate step per cycle, 4 steps x 8 quarter rounds x 10 double rounds,
// then the same adder folds in the initial state one word per cycle. The input is
// accepted while a result still waits in the output register. Write key, nonce and
// initial counter only while idle; a byte after one with tlast set starts a new
// message at the initial counter.
`include "chacha20_stream_cipher_top_macros.svh"

module chacha20_stream_cipher_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [cc20_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [cc20_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [7:0]                         s_axis_tdata_i,   // [7:0] data_in
  input  logic                               s_axis_tlast_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [7:0]                         m_axis_tdata_o,   // [7:0] data_out
  output logic                               m_axis_tlast_o
);

  cc20_pkg::key_t    key_q;
  logic [63:0]       nonce_lo_q;
  logic [31:0]       nonce_hi_q;
  cc20_pkg::word_t   init_ctr_q;

  cc20_pkg::word_t   ctr_q, ctr_eff, ctr_sel;
  logic [5:0]        pos_q, pos_eff;
  logic              in_msg_q;
  logic [7:0]        data_q;
  logic              last_q;
  logic              m_valid_q;
  logic [7:0]        m_data_q;
  logic              m_last_q;
  logic              s_acc;

  cc20_pkg::state_t  w_q, w_d, w_mix, init_cur;
  cc20_pkg::word_t   qa_in, qb_in, qa, qb, qc, qd;
  cc20_pkg::sts_t    sts;
  cc20_pkg::ctl_t    ctl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q      <= '0;
      nonce_lo_q <= '0;
      nonce_hi_q <= '0;
      init_ctr_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cc20_pkg::REG_KEY0:     key_q[0]   <= cfg_wdata_i;
        cc20_pkg::REG_KEY1:     key_q[1]   <= cfg_wdata_i;
        cc20_pkg::REG_KEY2:     key_q[2]   <= cfg_wdata_i;
        cc20_pkg::REG_KEY3:     key_q[3]   <= cfg_wdata_i;
        cc20_pkg::REG_NONCE_LO: nonce_lo_q <= cfg_wdata_i;
        cc20_pkg::REG_NONCE_HI: nonce_hi_q <= cfg_wdata_i[31:0];
        cc20_pkg::REG_INIT_CTR: init_ctr_q <= cfg_wdata_i[31:0];
        default: ;
      endcase
    end
  end

  assign ctr_eff = in_msg_q ? ctr_q : init_ctr_q;
  assign pos_eff = in_msg_q ? pos_q : '0;
  assign ctr_sel = ctl.load ? ctr_eff : ctr_q;
  assign init_cur = cc20_pkg::init_state(key_q, nonce_lo_q, nonce_hi_q, ctr_sel);

  assign sts.in_valid   = s_axis_tvalid_i;
  assign sts.need_block = (pos_eff == '0);
  assign sts.out_free   = !m_valid_q || m_axis_tready_i;

  cc20_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .ctl_o  (ctl)
  );

  assign s_axis_tready_o = ctl.ready;
  assign s_acc           = s_axis_tvalid_i && ctl.ready;

  assign qa_in = ctl.add_en ? w_q[ctl.idx] : w_q[0];
  assign qb_in = ctl.add_en ? init_cur[ctl.idx] : w_q[4];

  cc20_qr u_qr (
    .step_i (ctl.step),
    .a_i    (qa_in),
    .b_i    (qb_in),
    .c_i    (w_q[8]),
    .d_i    (w_q[12]),
    .a_o    (qa),
    .b_o    (qb),
    .c_o    (qc),
    .d_o    (qd)
  );

  always_comb begin
    w_mix     = w_q;
    w_mix[0]  = qa;
    w_mix[4]  = qb;
    w_mix[8]  = qc;
    w_mix[12] = qd;
    w_d       = w_q;
    if (ctl.load) begin
      w_d = init_cur;
    end else if (ctl.round_en) begin
      w_d = cc20_pkg::rot_rows(w_mix, ctl.rot);
    end else if (ctl.add_en) begin
      w_d[ctl.idx] = qa;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q <= w_d;
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      data_q <= s_axis_tdata_i;
      last_q <= s_axis_tlast_i;
    end
    if (ctl.emit) begin
      m_data_q <= data_q ^ w_q[pos_q[5:2]][8 * pos_q[1:0] +: 8];
      m_last_q <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q     <= '0;
      pos_q     <= '0;
      in_msg_q  <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      if (s_acc) begin
        ctr_q    <= ctr_eff;
        pos_q    <= pos_eff;
        in_msg_q <= 1'b1;
      end else if (ctl.ctr_inc) begin
        ctr_q <= ctr_q + 1'b1;
      end else if (ctl.emit) begin
        pos_q    <= last_q ? '0 : pos_q + 1'b1;
        in_msg_q <= !last_q;
      end
      if (ctl.emit) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tlast_o  = m_last_q;

  `CC20_ASSERT_NEXT(a_msg_start_block, s_acc && !in_msg_q, ctl.round_en, "message start without keystream block")
  `CC20_ASSERT_NEXT(a_emit_valid, ctl.emit, m_axis_tvalid_o, "result lost after emit")
  `CC20_ASSERT_NEXT(a_ctr_step, ctl.ctr_inc, ctr_q == $past(ctr_q) + 32'd1, "block counter did not advance")
  `CC20_ASSERT_NOW(a_busy_not_ready, ctl.round_en || ctl.add_en, !s_axis_tready_o, "input taken during block generation")

endmodule
